[rtl/nrbm_pkg.sv]
// ---------------------------------------------------------------------------
// nrbm_pkg
// Shared types, constants and the rule scoring function of the rule table.
// ---------------------------------------------------------------------------
`default_nettype none

package nrbm_pkg;

  // Score levels of the address part
  localparam logic [3:0] SCORE_EXACT = 4'd9;
  localparam logic [3:0] SCORE_P24   = 4'd7;
  localparam logic [3:0] SCORE_P16   = 4'd5;
  localparam logic [3:0] SCORE_P8    = 4'd3;
  localparam logic [3:0] SCORE_ANY   = 4'd1;
  localparam logic [3:0] SCORE_NONE  = 4'd0;

  // Function codes of an input word
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef logic [5:0] idx_out_t;

  // One stored rule
  typedef struct packed {
    logic               is_ipv4;
    logic [31:0]        address;
    logic [15:0]        port;
    logic signed [31:0] data;
  } rule_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic issue_rd;  // read next rule from the table
    logic publish;   // load the output register
  } nrbm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic table_empty;
    logic last_rd;     // read address is the last stored rule
    logic out_free;    // output register can take a word this cycle
  } nrbm_sts_t;

  // Score one rule against a query
  function automatic logic [3:0] score_rule(
    input logic        r_v4,
    input logic [31:0] r_addr,
    input logic [15:0] r_port,
    input logic        q_v4,
    input logic [31:0] q_addr,
    input logic [15:0] q_port
  );
    logic [3:0] base;
    logic [3:0] bonus;
    logic       port_ok;
    base    = SCORE_NONE;
    bonus   = {3'b000, (r_port != 16'h0000)};
    port_ok = (r_port == 16'h0000) || (r_port == q_port);
    if (r_addr == q_addr) begin
      base = SCORE_EXACT;
    end else if (r_addr[7:0] != 8'h00) begin
      base = SCORE_NONE;
    end else if (r_addr[31:8] == q_addr[31:8]) begin
      base = SCORE_P24;
    end else if (r_addr[15:8] != 8'h00) begin
      base = SCORE_NONE;
    end else if (r_addr[31:16] == q_addr[31:16]) begin
      base = SCORE_P16;
    end else if (r_addr[23:16] != 8'h00) begin
      base = SCORE_NONE;
    end else if (r_addr[31:24] == q_addr[31:24]) begin
      base = SCORE_P8;
    end else if (r_addr[31:24] != 8'h00) begin
      base = SCORE_NONE;
    end else begin
      base = SCORE_ANY;
    end
    if (!(r_v4 && q_v4) || !port_ok || (base == SCORE_NONE)) begin
      return SCORE_NONE;
    end
    return base + bonus;
  endfunction

endpackage

`default_nettype wire

[rtl/nrbm_ctrl.sv]
// ---------------------------------------------------------------------------
// nrbm_ctrl
// Sequencer of the rule table: accepts a word, steps the table scan and
// hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module nrbm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_func,
  output logic                     in_stall,
  input  nrbm_pkg::nrbm_sts_t      sts,
  output nrbm_pkg::nrbm_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_PUB   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_func == nrbm_pkg::FUNC_APPEND || sts.table_empty) begin
            state_nxt = S_PUB;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue_rd = 1'b1;
        if (sts.last_rd) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PUB;
      end
      S_PUB: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/nrbm_dp.sv]
// ---------------------------------------------------------------------------
// nrbm_dp
// Datapath of the rule table: rule memory, fill count, query registers,
// one-rule-per-cycle scoring and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module nrbm_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  nrbm_pkg::nrbm_cmd_t      cmd,
  output nrbm_pkg::nrbm_sts_t      sts,
  input  wire logic                in_func,
  input  wire logic                in_is_ipv4,
  input  wire logic [31:0]         in_ip_address,
  input  wire logic [15:0]         in_port_number,
  input  wire logic signed [31:0]  in_rule_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_found,
  output logic [5:0]               out_match_index,
  output logic signed [31:0]       out_match_value,
  output logic [3:0]               out_best_score,
  output logic                     out_rejected
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  nrbm_pkg::rule_t    mem [TABLE_DEPTH];
  nrbm_pkg::rule_t    rd_data_r;
  nrbm_pkg::rule_t    wr_rule;

  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [IDX_W-1:0]   rd_pos_r;
  logic               rd_vld_r;
  logic               full;

  logic               func_r;
  logic               rej_r;
  logic               q_v4_r;
  logic [31:0]        q_addr_r;
  logic [15:0]        q_port_r;

  logic [3:0]         best_r;
  logic [IDX_W-1:0]   win_idx_r;
  logic signed [31:0] win_val_r;
  logic [3:0]         cur_score;
  logic               found;

  logic               out_valid_r;
  logic               out_found_r;
  logic [5:0]         out_index_r;
  logic signed [31:0] out_value_r;
  logic [3:0]         out_score_r;
  logic               out_rej_r;

  assign full    = (count_r == CNT_W'(TABLE_DEPTH));
  assign wr_rule = '{is_ipv4: in_is_ipv4, address: in_ip_address,
                     port: in_port_number, data: in_rule_value};

  // Status to the sequencer
  assign sts.table_empty = (count_r == '0);
  assign sts.last_rd     = (CNT_W'(rd_idx_r) == count_r - CNT_W'(1));
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Rule memory: append on accept, scan read registered
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == nrbm_pkg::FUNC_APPEND) && !full) begin
      mem[count_r[IDX_W-1:0]] <= wr_rule;
    end
    if (cmd.issue_rd) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Fill count and read pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue_rd;
      if (cmd.accept && (in_func == nrbm_pkg::FUNC_APPEND) && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Latch the query and advance the scan address
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_func;
      rej_r    <= (in_func == nrbm_pkg::FUNC_APPEND) && full;
      q_v4_r   <= in_is_ipv4;
      q_addr_r <= in_ip_address;
      q_port_r <= in_port_number;
      rd_idx_r <= '0;
    end else if (cmd.issue_rd) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
    if (cmd.issue_rd) begin
      rd_pos_r <= rd_idx_r;
    end
  end

  assign cur_score = nrbm_pkg::score_rule(rd_data_r.is_ipv4, rd_data_r.address,
                                          rd_data_r.port, q_v4_r, q_addr_r, q_port_r);

  // Keep the first rule with the highest score
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      best_r    <= nrbm_pkg::SCORE_NONE;
      win_idx_r <= '0;
      win_val_r <= '0;
    end else if (rd_vld_r && (cur_score > best_r)) begin
      best_r    <= cur_score;
      win_idx_r <= rd_pos_r;
      win_val_r <= rd_data_r.data;
    end
  end

  assign found = (func_r == nrbm_pkg::FUNC_LOOKUP) && (best_r != nrbm_pkg::SCORE_NONE);

  // Output register: load on publish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_found_r <= found;
      out_index_r <= found ? nrbm_pkg::idx_out_t'(win_idx_r) : '0;
      out_value_r <= found ? win_val_r : '0;
      out_score_r <= found ? best_r : nrbm_pkg::SCORE_NONE;
      out_rej_r   <= rej_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;
  assign out_match_value = out_value_r;
  assign out_best_score  = out_score_r;
  assign out_rejected    = out_rej_r;

endmodule

`default_nettype wire

[rtl/network_rule_best_match_core.sv]
// ---------------------------------------------------------------------------
// network_rule_best_match_core
// Best-match table of IPv4 address/port rules, one result word per input.
// ---------------------------------------------------------------------------
// An append word stores a rule in the next free slot (rejected when the
// table holds TABLE_DEPTH rules) and goes from acceptance straight to the
// publish state, which loads its result into the output register. A lookup
// word scans the stored rules through the single read port of the rule
// memory, one rule per cycle, then passes the drain state before the
// publish state; on an empty table it goes straight to publish. One word is
// worked on at a time; the input stalls from the cycle after acceptance
// until the result is loaded into the output register, which then holds it
// until the receiver takes it. The publish state waits while the output
// register still holds an earlier result that the receiver has not taken.
// The rule memory needs no clearing after reset.
`default_nettype none

module network_rule_best_match_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_func,
  input  wire logic                in_is_ipv4,
  input  wire logic [31:0]         in_ip_address,
  input  wire logic [15:0]         in_port_number,
  input  wire logic signed [31:0]  in_rule_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_found,
  output logic [5:0]               out_match_index,
  output logic signed [31:0]       out_match_value,
  output logic [3:0]               out_best_score,
  output logic                     out_rejected
);

  nrbm_pkg::nrbm_cmd_t cmd;
  nrbm_pkg::nrbm_sts_t sts;

  // Sequencer
  nrbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Rule store and scoring
  nrbm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_is_ipv4      (in_is_ipv4),
    .in_ip_address   (in_ip_address),
    .in_port_number  (in_port_number),
    .in_rule_value   (in_rule_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .out_match_value (out_match_value),
    .out_best_score  (out_best_score),
    .out_rejected    (out_rejected)
  );

endmodule

`default_nettype wire
